[hdl/btr_pkg.sv]
// package for the bilinear table resampler
// codes and fixed field widths shared by the top level and the table bank, no dependencies
`timescale 1ns / 1ps
package btr_pkg;

  localparam int ROW_W      = 5;
  localparam int ELEM_W     = 6;
  localparam int POS_W      = 6;
  localparam int VALUE_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_SIZE   = 2'd0,
    CFG_HIDDEN_DIM = 2'd1,
    CFG_GRID_H     = 2'd2,
    CFG_GRID_W     = 2'd3
  } cfg_idx_e;

endpackage

[hdl/btr_div.sv]
// pipelined restoring divider, SPS quotient bits per stage
// stage enables come from the top level; uses no package items
`timescale 1ns / 1ps
module btr_div #(
  parameter int NS  = 8,
  parameter int SPS = 4,
  parameter int DW  = 29,
  parameter int VW  = 9
) (
  input  logic              clk_i,
  input  logic [NS-1:0]     en_i,
  input  logic [DW-1:0]     dividend_i,
  input  logic [VW-1:0]     divisor_i,
  output logic [NS*SPS-1:0] quotient_o
);

  localparam int PW = NS * SPS;

  logic [VW-1:0] rem_q [NS];
  logic [PW-1:0] dvd_q [NS];
  logic [PW-1:0] quo_q [NS];
  logic [VW-1:0] rem_d [NS];
  logic [PW-1:0] dvd_d [NS];
  logic [PW-1:0] quo_d [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    always_comb begin
      logic [VW:0] t;
      logic [VW-1:0] rem;
      logic [PW-1:0] dvd;
      logic [PW-1:0] quo;
      if (j == 0) begin
        rem = '0;
        dvd = PW'(dividend_i);
        quo = '0;
      end else begin
        rem = rem_q[j-1];
        dvd = dvd_q[j-1];
        quo = quo_q[j-1];
      end
      for (int s = 0; s < SPS; s++) begin
        t   = {rem, dvd[PW-1]};
        dvd = {dvd[PW-2:0], 1'b0};
        if (t >= {1'b0, divisor_i}) begin
          t   = t - {1'b0, divisor_i};
          quo = {quo[PW-2:0], 1'b1};
        end else begin
          quo = {quo[PW-2:0], 1'b0};
        end
        rem = t[VW-1:0];
      end
      rem_d[j] = rem;
      dvd_d[j] = dvd;
      quo_d[j] = quo;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d[j];
        dvd_q[j] <= dvd_d[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  assign quotient_o = quo_q[NS-1];

endmodule

[hdl/btr_bank.sv]
// one parity bank of the reference table, one write and one read port
// read data registered; uses btr_pkg for the value width
`timescale 1ns / 1ps
module btr_bank #(
  parameter int AW = 14
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic signed [btr_pkg::VALUE_W-1:0] wdata_i,
  input  logic                               re_i,
  input  logic [AW-1:0]                      raddr_i,
  output logic signed [btr_pkg::VALUE_W-1:0] rdata_o
);

  logic signed [btr_pkg::VALUE_W-1:0] mem [2**AW];
  logic signed [btr_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bilinear_table_resampler.sv]
// bilinear resampler of a banked square table of vectors onto a target grid
// depends on btr_pkg, btr_div (coordinate division) and btr_bank (table)
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------------
//  in       | sink      | in_valid_i / in_stall_o  | action, table_*, out_row/col/elem
//  out      | source    | out_valid_o / out_stall_i| interp_value
//  cfg      | sink      | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// one item per cycle while out_stall_i is low; a query passes the input register,
// NS = ceil(DW/4) stages of the coordinate divider (8 at the defaults), then stages A, R, P, S, Q and O
// loads pass down the same pipe and write the table at the corner read stage
// each stage holds while the one after it is full and held, so stalls ripple back
// reset clears the valid bits and loads the register defaults; the table is not cleared
`timescale 1ns / 1ps
module bilinear_table_resampler #(
  parameter int REF_MAX    = 32,
  parameter int HIDDEN_MAX = 64,
  parameter int GRID_MAX   = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [btr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [btr_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic [btr_pkg::ROW_W-1:0]             table_row_i,
  input  logic [btr_pkg::ROW_W-1:0]             table_col_i,
  input  logic [btr_pkg::ELEM_W-1:0]            table_elem_i,
  input  logic signed [btr_pkg::VALUE_W-1:0]    table_value_i,
  input  logic [btr_pkg::POS_W-1:0]             out_row_i,
  input  logic [btr_pkg::POS_W-1:0]             out_col_i,
  input  logic [btr_pkg::ELEM_W-1:0]            out_elem_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [btr_pkg::VALUE_W-1:0]    interp_value_o
);

  localparam int FW   = btr_pkg::FRAC_W;
  localparam int VLW  = btr_pkg::VALUE_W;
  localparam int RW   = $clog2(REF_MAX + 1);
  localparam int HW   = $clog2(HIDDEN_MAX + 1);
  localparam int GW   = $clog2(GRID_MAX + 1);
  localparam int LW   = $clog2(REF_MAX);
  localparam int HALF = (REF_MAX + 1) / 2;
  localparam int HRW  = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int EW   = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
  localparam int BAW  = 2 * HRW + EW;
  localparam int TMAX = (1 << btr_pkg::POS_W) - 1;
  localparam int NW   = $clog2((2 * TMAX + 1) * REF_MAX + 1);
  localparam int DW   = NW + FW + 1;
  localparam int VW   = $clog2(4 * GRID_MAX + 1);
  localparam int SPS  = 4;
  localparam int NS   = (DW + SPS - 1) / SPS;
  localparam int PW   = NS * SPS;
  localparam int QW   = PW - FW;
  localparam int ST_A = NS + 1;
  localparam int ST_R = NS + 2;
  localparam int ST_P = NS + 3;
  localparam int ST_S = NS + 4;
  localparam int ST_Q = NS + 5;
  localparam int ST_O = NS + 6;
  localparam int NST  = NS + 7;

  typedef struct packed {
    btr_pkg::action_e              act;
    logic [btr_pkg::ROW_W-1:0]     trow;
    logic [btr_pkg::ROW_W-1:0]     tcol;
    logic [btr_pkg::ELEM_W-1:0]    telem;
    logic signed [VLW-1:0]         tval;
    logic                          neg_y;
    logic                          neg_x;
    logic [btr_pkg::ELEM_W-1:0]    oelem;
    logic                          oob;
  } side_t;

  // configuration
  logic [5:0] ref_size_q;
  logic [6:0] hidden_dim_q, grid_h_q, grid_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_size_q   <= 6'd16;
      hidden_dim_q <= 7'd64;
      grid_h_q     <= 7'd32;
      grid_w_q     <= 7'd32;
    end else if (cfg_we_i) begin
      unique case (btr_pkg::cfg_idx_e'(cfg_idx_i))
        btr_pkg::CFG_REF_SIZE:   ref_size_q   <= cfg_wdata_i[5:0];
        btr_pkg::CFG_HIDDEN_DIM: hidden_dim_q <= cfg_wdata_i;
        btr_pkg::CFG_GRID_H:     grid_h_q     <= cfg_wdata_i;
        btr_pkg::CFG_GRID_W:     grid_w_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [RW-1:0] r_eff;
  logic [HW-1:0] h_eff;
  logic [GW-1:0] gh_eff, gw_eff;

  always_comb begin
    if (ref_size_q == '0) r_eff = RW'(1);
    else if (32'(ref_size_q) > REF_MAX) r_eff = RW'(REF_MAX);
    else r_eff = RW'(ref_size_q);
    if (hidden_dim_q == '0) h_eff = HW'(1);
    else if (32'(hidden_dim_q) > HIDDEN_MAX) h_eff = HW'(HIDDEN_MAX);
    else h_eff = HW'(hidden_dim_q);
    if (grid_h_q == '0) gh_eff = GW'(1);
    else if (32'(grid_h_q) > GRID_MAX) gh_eff = GW'(GRID_MAX);
    else gh_eff = GW'(grid_h_q);
    if (grid_w_q == '0) gw_eff = GW'(1);
    else if (32'(grid_w_q) > GRID_MAX) gw_eff = GW'(GRID_MAX);
    else gw_eff = GW'(grid_w_q);
  end

  // stage valid bits and enables
  logic [NST-1:0] v_q, v_d, en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // stage 0: input register
  btr_pkg::action_e             act0_q;
  logic [btr_pkg::ROW_W-1:0]    trow0_q, tcol0_q;
  logic [btr_pkg::ELEM_W-1:0]   telem0_q, oelem0_q;
  logic signed [VLW-1:0]        tval0_q;
  logic [btr_pkg::POS_W-1:0]    orow0_q, ocol0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      act0_q   <= btr_pkg::action_e'(action_i);
      trow0_q  <= table_row_i;
      tcol0_q  <= table_col_i;
      telem0_q <= table_elem_i;
      tval0_q  <= table_value_i;
      orow0_q  <= out_row_i;
      ocol0_q  <= out_col_i;
      oelem0_q <= out_elem_i;
    end
  end

  // numerator (2t+1)*r - g, dividend n*2^17 + 2g, divisor 4g
  logic [NW:0]   py, px, ny, nx;
  logic          neg_y, neg_x;
  logic [DW-1:0] dvd_y, dvd_x;
  logic [VW-1:0] dsr_y, dsr_x;
  side_t         side0;

  always_comb begin
    py    = (NW+1)'({orow0_q, 1'b1}) * (NW+1)'(r_eff);
    px    = (NW+1)'({ocol0_q, 1'b1}) * (NW+1)'(r_eff);
    neg_y = py < (NW+1)'(gh_eff);
    neg_x = px < (NW+1)'(gw_eff);
    ny    = neg_y ? '0 : py - (NW+1)'(gh_eff);
    nx    = neg_x ? '0 : px - (NW+1)'(gw_eff);
    dvd_y = {ny[NW-1:0], (FW+1)'({gh_eff, 1'b0})};
    dvd_x = {nx[NW-1:0], (FW+1)'({gw_eff, 1'b0})};
    dsr_y = VW'({gh_eff, 2'b00});
    dsr_x = VW'({gw_eff, 2'b00});
    side0.act   = act0_q;
    side0.trow  = trow0_q;
    side0.tcol  = tcol0_q;
    side0.telem = telem0_q;
    side0.tval  = tval0_q;
    side0.neg_y = neg_y;
    side0.neg_x = neg_x;
    side0.oelem = oelem0_q;
    side0.oob   = 32'(oelem0_q) >= 32'(h_eff);
  end

  logic [PW-1:0] quo_y, quo_x;

  btr_div #(.NS(NS), .SPS(SPS), .DW(DW), .VW(VW)) u_div_y (
    .clk_i      (clk_i),
    .en_i       (en[NS:1]),
    .dividend_i (dvd_y),
    .divisor_i  (dsr_y),
    .quotient_o (quo_y)
  );

  btr_div #(.NS(NS), .SPS(SPS), .DW(DW), .VW(VW)) u_div_x (
    .clk_i      (clk_i),
    .en_i       (en[NS:1]),
    .dividend_i (dvd_x),
    .divisor_i  (dsr_x),
    .quotient_o (quo_x)
  );

  side_t side_q [1:NS];

  always_ff @(posedge clk_i) begin
    for (int j = 1; j <= NS; j++) begin
      if (en[j]) begin
        side_q[j] <= (j == 1) ? side0 : side_q[j-1];
      end
    end
  end

  // corner indices and weights from the quotient: integer part and fraction
  logic [LW-1:0] y0_d, y1_d, x0_d, x1_d;
  logic [FW-1:0] wy_d, wx_d;
  logic [LW-1:0] rlast;

  always_comb begin
    rlast = LW'(r_eff - RW'(1));
    if (side_q[NS].neg_y) begin
      y0_d = '0; y1_d = '0; wy_d = '0;
    end else if (quo_y[PW-1:FW] >= QW'(rlast)) begin
      y0_d = rlast; y1_d = rlast; wy_d = '0;
    end else begin
      y0_d = LW'(quo_y[PW-1:FW]);
      y1_d = LW'(quo_y[PW-1:FW]) + LW'(1);
      wy_d = quo_y[FW-1:0];
    end
    if (side_q[NS].neg_x) begin
      x0_d = '0; x1_d = '0; wx_d = '0;
    end else if (quo_x[PW-1:FW] >= QW'(rlast)) begin
      x0_d = rlast; x1_d = rlast; wx_d = '0;
    end else begin
      x0_d = LW'(quo_x[PW-1:FW]);
      x1_d = LW'(quo_x[PW-1:FW]) + LW'(1);
      wx_d = quo_x[FW-1:0];
    end
  end

  // stage A: corner addresses, table write for loads
  logic [LW-1:0] y0_q, y1_q, x0_q, x1_q;
  logic [FW-1:0] wy_a_q, wx_a_q;
  side_t         side_a_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_A]) begin
      y0_q     <= y0_d;
      y1_q     <= y1_d;
      x0_q     <= x0_d;
      x1_q     <= x1_d;
      wy_a_q   <= wy_d;
      wx_a_q   <= wx_d;
      side_a_q <= side_q[NS];
    end
  end

  logic           load_ok, wr_go, rd_go;
  logic [BAW-1:0] waddr;
  logic [BAW-1:0] raddr [4];
  logic [3:0]     bank_we;
  logic signed [VLW-1:0] rdata [4];

  always_comb begin
    logic [LW-1:0] ys, xs;
    load_ok = (32'(side_a_q.trow) < REF_MAX) && (32'(side_a_q.tcol) < REF_MAX) &&
              (32'(side_a_q.telem) < HIDDEN_MAX);
    wr_go   = v_q[ST_A] && en[ST_R] && (side_a_q.act == btr_pkg::ACT_LOAD) && load_ok;
    rd_go   = en[ST_R];
    waddr   = {HRW'(side_a_q.trow >> 1), HRW'(side_a_q.tcol >> 1), EW'(side_a_q.telem)};
    for (int b = 0; b < 4; b++) begin
      ys = (y0_q[0] == b[1]) ? y0_q : y1_q;
      xs = (x0_q[0] == b[0]) ? x0_q : x1_q;
      raddr[b]   = {HRW'(ys >> 1), HRW'(xs >> 1), EW'(side_a_q.oelem)};
      bank_we[b] = wr_go && (side_a_q.trow[0] == b[1]) && (side_a_q.tcol[0] == b[0]);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    btr_bank #(.AW(BAW)) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (waddr),
      .wdata_i (side_a_q.tval),
      .re_i    (rd_go),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  // stage R: bank data plus corner parities
  logic          py0_q, py1_q, px0_q, px1_q, oob_r_q;
  logic [FW-1:0] wy_r_q, wx_r_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_R]) begin
      py0_q   <= y0_q[0];
      py1_q   <= y1_q[0];
      px0_q   <= x0_q[0];
      px1_q   <= x1_q[0];
      wy_r_q  <= wy_a_q;
      wx_r_q  <= wx_a_q;
      oob_r_q <= side_a_q.oob;
    end
  end

  // stage P: horizontal products
  logic signed [VLW-1:0] p00, p01, p10, p11;
  logic [FW:0]           wxc;
  logic signed [33:0]    pa_d, pb_d, pc_d, pd_d, pa_q, pb_q, pc_q, pd_q;
  logic [FW-1:0]         wy_p_q;
  logic                  oob_p_q;

  always_comb begin
    p00  = rdata[{py0_q, px0_q}];
    p01  = rdata[{py0_q, px1_q}];
    p10  = rdata[{py1_q, px0_q}];
    p11  = rdata[{py1_q, px1_q}];
    wxc  = (FW+1)'(1 << FW) - {1'b0, wx_r_q};
    pa_d = p00 * $signed({1'b0, wxc});
    pb_d = p01 * $signed({2'b00, wx_r_q});
    pc_d = p10 * $signed({1'b0, wxc});
    pd_d = p11 * $signed({2'b00, wx_r_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_P]) begin
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      pc_q    <= pc_d;
      pd_q    <= pd_d;
      wy_p_q  <= wy_r_q;
      oob_p_q <= oob_r_q;
    end
  end

  // stage S: row sums
  logic signed [34:0] top_q, bot_q;
  logic [FW-1:0]      wy_s_q;
  logic               oob_s_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_S]) begin
      top_q   <= 35'(pa_q) + 35'(pb_q);
      bot_q   <= 35'(pc_q) + 35'(pd_q);
      wy_s_q  <= wy_p_q;
      oob_s_q <= oob_p_q;
    end
  end

  // stage Q: vertical products
  logic [FW:0]        wyc;
  logic signed [52:0] m0_d, m1_d, m0_q, m1_q;
  logic               oob_q_q;

  always_comb begin
    wyc  = (FW+1)'(1 << FW) - {1'b0, wy_s_q};
    m0_d = top_q * $signed({1'b0, wyc});
    m1_d = bot_q * $signed({2'b00, wy_s_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_Q]) begin
      m0_q    <= m0_d;
      m1_q    <= m1_d;
      oob_q_q <= oob_s_q;
    end
  end

  // stage O: round to nearest, ties up, from 32 fraction bits
  logic signed [53:0]    total;
  logic signed [VLW-1:0] res_q;

  assign total = 54'(m0_q) + 54'(m1_q) + 54'sd2147483648;

  always_ff @(posedge clk_i) begin
    if (en[ST_O]) begin
      res_q <= oob_q_q ? '0 : total[47:32];
    end
  end

  // valid bits; loads leave the pipe after the table write
  always_comb begin
    v_d[0] = in_valid_i;
    for (int k = 1; k < NST; k++) begin
      v_d[k] = v_q[k-1];
    end
    v_d[ST_R] = v_q[ST_A] && (side_a_q.act == btr_pkg::ACT_QUERY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_d[k];
      end
    end
  end

  assign in_stall_o     = !en[0];
  assign out_valid_o    = v_q[ST_O];
  assign interp_value_o = res_q;

  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input held while output side is free");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v_q[0])
    else $error("input held with an empty first stage");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[ST_Q]))
    else $error("result appeared without an item in the stage before");

  a_no_rw_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|bank_we) |-> (v_q[ST_A] && side_a_q.act == btr_pkg::ACT_LOAD && $onehot(bank_we)))
    else $error("table write without a load item in the read stage");

endmodule
